@@ sv/extended_euclid_gcd_assert.svh @@
// assertion macros for the extended euclid gcd block
`ifndef EXTENDED_EUCLID_GCD_ASSERT_SVH
`define EXTENDED_EUCLID_GCD_ASSERT_SVH

// same-cycle implication, checked out of reset
`define EEG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define EEG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/eeg_pkg.sv @@
// package for the extended euclid gcd block
`timescale 1ns / 1ps
`default_nettype none
package eeg_pkg;
    localparam int OPERAND_WIDTH_DEF = 64;
    localparam int FIELD_WIDTH = 64;
    localparam int COEF_WIDTH = 64;
endpackage
`default_nettype wire

@@ sv/eeg_div_unit.sv @@
// shared restoring divider with horner accumulation of quotient times coefficients
`timescale 1ns / 1ps
`default_nettype none
module eeg_div_unit
    import eeg_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [OPERAND_WIDTH-1:0] dividend,
    input  wire logic [OPERAND_WIDTH-1:0] divisor,
    input  wire logic [COEF_WIDTH-1:0]    mult_x,
    input  wire logic [COEF_WIDTH-1:0]    mult_y,
    output logic                          done,
    output logic [OPERAND_WIDTH-1:0]      remainder,
    output logic [COEF_WIDTH-1:0]         prod_x,
    output logic [COEF_WIDTH-1:0]         prod_y
);
    localparam int CW = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [OPERAND_WIDTH-1:0] dvd_reg, dvd_next;
    logic [OPERAND_WIDTH-1:0] rem_reg, rem_next;
    logic [COEF_WIDTH-1:0]    accx_reg, accx_next;
    logic [COEF_WIDTH-1:0]    accy_reg, accy_next;
    logic [OPERAND_WIDTH:0]   trial;
    logic                     fits;

    // one quotient bit per cycle, msb first
    assign trial = {rem_reg, dvd_reg[OPERAND_WIDTH-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        accx_next = accx_reg;
        accy_next = accy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(OPERAND_WIDTH - 1);
            dvd_next  = dividend;
            rem_next  = '0;
            accx_next = '0;
            accy_next = '0;
        end
        else if (busy_reg)
        begin
            dvd_next  = dvd_reg << 1;
            rem_next  = fits ? OPERAND_WIDTH'(trial - {1'b0, divisor})
                             : OPERAND_WIDTH'(trial);
            accx_next = (accx_reg << 1) + (fits ? mult_x : '0);
            accy_next = (accy_reg << 1) + (fits ? mult_y : '0);
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        accx_reg <= accx_next;
        accy_reg <= accy_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
    assign prod_x    = accx_reg;
    assign prod_y    = accy_reg;
endmodule
`default_nettype wire

@@ sv/extended_euclid_gcd.sv @@
// top level of the extended euclid gcd block
// usage:
//   input channel in_valid/in_ready carries operand_a and operand_b; a transfer
//   happens when both are high. only the low OPERAND_WIDTH bits are used
//   output channel out_valid/out_ready carries divisor, coef_x, coef_y with
//   operand_a*coef_x + operand_b*coef_y == divisor (coefs two's complement)
// operation:
//   each quotient step starts the shared restoring divider from the check
//   state and waits for its done in the div state, which then updates a, b
//   and the coefficients; the number of euclid divisions is zero when
//   operand_b is zero and at most ~93 at 64 bits
//   the divider yields one quotient bit per cycle
// flow:
//   in_ready is high only while idle; one item at a time
//   the result is held stable in output registers until its transfer
//   a stalled receiver keeps the block from taking the next item
// reset:
//   asynchronous active-low reset returns to idle with out_valid low
`timescale 1ns / 1ps
`default_nettype none
module extended_euclid_gcd
    import eeg_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [FIELD_WIDTH-1:0] operand_a,
    input  wire logic [FIELD_WIDTH-1:0] operand_b,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [FIELD_WIDTH-1:0]      divisor,
    output logic signed [COEF_WIDTH-1:0] coef_x,
    output logic signed [COEF_WIDTH-1:0] coef_y
);
    typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_DIV, ST_OUT} state_t;

    state_t                   state_reg;
    logic [OPERAND_WIDTH-1:0] a_reg, b_reg;
    // coefficients for a (p) and for b (c)
    logic [COEF_WIDTH-1:0]    px_reg, py_reg, cx_reg, cy_reg;
    logic [FIELD_WIDTH-1:0]   gcd_reg;
    logic [COEF_WIDTH-1:0]    ox_reg, oy_reg;

    logic                     div_start;
    logic                     div_done;
    logic [OPERAND_WIDTH-1:0] div_rem;
    logic [COEF_WIDTH-1:0]    div_px, div_py;

    // start the divider when a nonzero divisor is seen
    assign div_start = (state_reg == ST_CHECK) && (b_reg != '0);

    eeg_div_unit #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .mult_x    (cx_reg),
        .mult_y    (cy_reg),
        .done      (div_done),
        .remainder (div_rem),
        .prod_x    (div_px),
        .prod_y    (div_py)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        a_reg     <= operand_a[OPERAND_WIDTH-1:0];
                        b_reg     <= operand_b[OPERAND_WIDTH-1:0];
                        px_reg    <= COEF_WIDTH'(1);
                        py_reg    <= '0;
                        cx_reg    <= '0;
                        cy_reg    <= COEF_WIDTH'(1);
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (b_reg == '0)
                    begin
                        gcd_reg   <= FIELD_WIDTH'(a_reg);
                        ox_reg    <= px_reg;
                        oy_reg    <= py_reg;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    // (a,b) <- (b, a mod b); (p,c) <- (c, p - q*c)
                    if (div_done)
                    begin
                        a_reg     <= b_reg;
                        b_reg     <= div_rem;
                        px_reg    <= cx_reg;
                        py_reg    <= cy_reg;
                        cx_reg    <= px_reg - div_px;
                        cy_reg    <= py_reg - div_py;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign divisor   = gcd_reg;
    assign coef_x    = ox_reg;
    assign coef_y    = oy_reg;
endmodule
`default_nettype wire

@@ sv/eeg_checker.sv @@
// port-level checker for the extended euclid gcd block, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "extended_euclid_gcd_assert.svh"
module eeg_checker
    import eeg_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [FIELD_WIDTH-1:0] divisor,
    input wire logic [COEF_WIDTH-1:0]  coef_x,
    input wire logic [COEF_WIDTH-1:0]  coef_y
);
    // a held result stays put
    `EEG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(divisor) && $stable(coef_x) && $stable(coef_y),
        "result changed while stalled")
    // one item in flight at a time
    `EEG_ASSERT_NOW(a_one_item, out_valid, !in_ready, "input open while result pending")
    // a result never appears in the cycle after an input transfer
    `EEG_ASSERT_NEXT(a_min_latency, in_valid && in_ready, !out_valid && !in_ready,
        "result too early")
    // after a result transfer the block is idle again
    `EEG_ASSERT_NEXT(a_back_idle, out_valid && out_ready, in_ready && !out_valid,
        "not idle after result transfer")
endmodule

bind extended_euclid_gcd eeg_checker u_eeg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .divisor   (divisor),
    .coef_x    (coef_x),
    .coef_y    (coef_y)
);
`default_nettype wire
